// ----- rtl/core/fmfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmfs_pkg
// Shared types, constants and helpers for the Fourier mode field synthesiser.
// ----------------------------------------------------------------------------
package fmfs_pkg;

    localparam int DEF_MAX_MODES = 256;
    localparam int DEF_WAVE_BITS = 8;
    localparam int DEF_CNT_W     = 9;

    localparam int CORDIC_STEPS = 30;
    localparam int STEP_W       = 5;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [2:0] FUNC_LOAD_K    = 3'd0;
    localparam logic [2:0] FUNC_LOAD_A    = 3'd1;
    localparam logic [2:0] FUNC_LOAD_B    = 3'd2;
    localparam logic [2:0] FUNC_LOAD_COEF = 3'd3;
    localparam logic [2:0] FUNC_VELOCITY  = 3'd4;
    localparam logic [2:0] FUNC_FORCE     = 3'd5;
    localparam logic [2:0] FUNC_CLEAR     = 3'd6;

    localparam logic [1:0] PART_K    = 2'd0;
    localparam logic [1:0] PART_A    = 2'd1;
    localparam logic [1:0] PART_B    = 2'd2;
    localparam logic [1:0] PART_COEF = 2'd3;

    localparam logic [2:0] CFG_ENABLE     = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_X   = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Y   = 3'd2;
    localparam logic [2:0] CFG_ORIGIN_Z   = 3'd3;
    localparam logic [2:0] CFG_INV_LEN_X  = 3'd4;
    localparam logic [2:0] CFG_INV_LEN_Y  = 3'd5;
    localparam logic [2:0] CFG_INV_LEN_Z  = 3'd6;
    localparam logic [2:0] CFG_FORCE_GAIN = 3'd7;

    typedef struct packed {
        logic       en;
        logic [1:0] part;
    } fmfs_wr_t;

    function automatic logic [29:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [29:0] r;
        begin
            case (i)
                5'd0:    r = 30'd536870912;
                5'd1:    r = 30'd316933406;
                5'd2:    r = 30'd167458907;
                5'd3:    r = 30'd85004756;
                5'd4:    r = 30'd42667331;
                5'd5:    r = 30'd21354465;
                5'd6:    r = 30'd10679838;
                5'd7:    r = 30'd5340245;
                5'd8:    r = 30'd2670163;
                5'd9:    r = 30'd1335087;
                5'd10:   r = 30'd667544;
                5'd11:   r = 30'd333772;
                5'd12:   r = 30'd166886;
                5'd13:   r = 30'd83443;
                5'd14:   r = 30'd41722;
                5'd15:   r = 30'd20861;
                5'd16:   r = 30'd10430;
                5'd17:   r = 30'd5215;
                5'd18:   r = 30'd2608;
                5'd19:   r = 30'd1304;
                5'd20:   r = 30'd652;
                5'd21:   r = 30'd326;
                5'd22:   r = 30'd163;
                5'd23:   r = 30'd81;
                5'd24:   r = 30'd41;
                5'd25:   r = 30'd20;
                5'd26:   r = 30'd10;
                5'd27:   r = 30'd5;
                5'd28:   r = 30'd3;
                5'd29:   r = 30'd1;
                default: r = 30'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        begin
            if (v > 66'sd2147483647)
                r = 32'sh7fffffff;
            else if (v < -66'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

// ----- rtl/core/fmfs_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmfs_if
// Item and result channels of the Fourier mode field synthesiser.
// ----------------------------------------------------------------------------
interface fmfs_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic [7:0]         mode_index;
    logic signed [31:0] val_a;
    logic signed [31:0] val_b;
    logic signed [31:0] val_c;

    modport source (output valid, func, mode_index, val_a, val_b, val_c, input ready);
    modport sink   (input valid, func, mode_index, val_a, val_b, val_c, output ready);
endinterface

interface fmfs_out_if #(parameter int CNT_W = fmfs_pkg::DEF_CNT_W);
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [CNT_W-1:0]   modes_loaded;

    modport source (output valid, out_x, out_y, out_z, modes_loaded, input ready);
    modport sink   (input valid, out_x, out_y, out_z, modes_loaded, output ready);
endinterface

// ----- rtl/core/fmfs_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmfs_cordic
// Iterative rotation unit: cosine and sine of a phase in turns, one step a cycle.
// ----------------------------------------------------------------------------
module fmfs_cordic
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        phase,
    output logic               done,
    output logic signed [31:0] cos_out,
    output logic signed [31:0] sin_out
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [fmfs_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [1:0]                     quad_reg, quad_next;
    logic signed [33:0]             x_reg, x_next;
    logic signed [33:0]             y_reg, y_next;
    logic signed [31:0]             z_reg, z_next;
    logic signed [33:0]             dx, dy;
    logic signed [31:0]             ang;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quad_next = quad_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        dx        = y_reg >>> step_reg;
        dy        = x_reg >>> step_reg;
        ang       = $signed({2'b00, fmfs_pkg::atan_turn(step_reg)});
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quad_next = phase[31:30];
            x_next    = fmfs_pkg::CORDIC_GAIN;
            y_next    = '0;
            z_next    = $signed({2'b00, phase[29:0]});
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - ang;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + ang;
            end
            if (step_reg == fmfs_pkg::STEP_W'(fmfs_pkg::CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            quad_reg <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            quad_reg <= quad_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
        end
    end

    logic signed [33:0] nx, ny;
    assign nx = -x_reg;
    assign ny = -y_reg;

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                cos_out = x_reg[31:0];
                sin_out = y_reg[31:0];
            end
            2'd1:
            begin
                cos_out = ny[31:0];
                sin_out = x_reg[31:0];
            end
            2'd2:
            begin
                cos_out = nx[31:0];
                sin_out = ny[31:0];
            end
            default:
            begin
                cos_out = y_reg[31:0];
                sin_out = nx[31:0];
            end
        endcase
    end

    assign done = done_reg;

endmodule

// ----- rtl/core/fmfs_mode_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmfs_mode_table
// Mode storage: wavevector, cosine and sine amplitudes and forcing coefficient.
// ----------------------------------------------------------------------------
module fmfs_mode_table #(
    parameter int MAX_MODES = fmfs_pkg::DEF_MAX_MODES,
    parameter int WAVE_BITS = fmfs_pkg::DEF_WAVE_BITS,
    parameter int IDX_W     = 8
)
(
    input  logic                   clk,
    input  fmfs_pkg::fmfs_wr_t     wr,
    input  logic [IDX_W-1:0]       wr_addr,
    input  logic [3*WAVE_BITS-1:0] wr_k,
    input  logic [95:0]            wr_v,
    input  logic                   rd_en,
    input  logic [IDX_W-1:0]       rd_addr,
    output logic [3*WAVE_BITS-1:0] rd_k,
    output logic [95:0]            rd_a,
    output logic [95:0]            rd_b,
    output logic [31:0]            rd_c
);

    logic [3*WAVE_BITS-1:0] k_mem [MAX_MODES];
    logic [95:0]            a_mem [MAX_MODES];
    logic [95:0]            b_mem [MAX_MODES];
    logic [31:0]            c_mem [MAX_MODES];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            case (wr.part)
                fmfs_pkg::PART_K: k_mem[wr_addr] <= wr_k;
                fmfs_pkg::PART_A: a_mem[wr_addr] <= wr_v;
                fmfs_pkg::PART_B: b_mem[wr_addr] <= wr_v;
                default:          c_mem[wr_addr] <= wr_v[31:0];
            endcase
        end
        if (rd_en)
        begin
            rd_k <= k_mem[rd_addr];
            rd_a <= a_mem[rd_addr];
            rd_b <= b_mem[rd_addr];
            rd_c <= c_mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/fourier_mode_field_synth.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fourier_mode_field_synth
// Sums a*cos + b*sin over a table of Fourier modes at a point, or the forcing.
// ----------------------------------------------------------------------------
// Load, clear and unused items post their result in the cycle after they are
// taken. A velocity or force item runs setup, then per loaded mode a read,
// phase, rotation and per axis a cos and sin product (force adds gain steps),
// then posts the result once the output is free; the 30-step rotation unit and
// the single shared 33x33 multiplier set the pace. Items are taken one at a
// time; the table keeps its contents over a clear; unwritten entries are junk.
module fourier_mode_field_synth #(
    parameter int MAX_MODES = fmfs_pkg::DEF_MAX_MODES,
    parameter int WAVE_BITS = fmfs_pkg::DEF_WAVE_BITS,
    parameter int CNT_W     = $clog2(MAX_MODES + 1)
)
(
    input  logic        clk,
    input  logic        rst_n,
    fmfs_in_if.sink     item,
    fmfs_out_if.source  result,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int IDX_W = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
    localparam int XW    = (CNT_W > 9) ? CNT_W : 9;
    localparam logic signed [31:0] KMAX = 32'(2 ** (WAVE_BITS - 1) - 1);
    localparam logic signed [31:0] KMIN = -KMAX - 32'sd1;

    typedef enum logic [4:0] {
        S_IDLE, S_FRAC0, S_FRAC1, S_FRAC2, S_FRAC3, S_RD,
        S_PH0, S_PH1, S_PH2, S_PH3, S_CW, S_G0, S_G1,
        S_A0, S_A1, S_A2, S_A3, S_A4, S_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic                       enable_reg, enable_next;
    logic signed [31:0]         org_reg [3];
    logic signed [31:0]         org_next [3];
    logic [30:0]                inv_reg [3];
    logic [30:0]                inv_next [3];
    logic signed [31:0]         gain_reg, gain_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           mi_reg, mi_next;
    logic [1:0]                 ax_reg, ax_next;
    logic                       force_reg, force_next;
    logic [31:0]                d_reg [3];
    logic [31:0]                d_next [3];
    logic [31:0]                f_reg [3];
    logic [31:0]                f_next [3];
    logic [31:0]                ph_reg, ph_next;
    logic signed [65:0]         prod_reg;
    logic signed [65:0]         t_reg, t_next;
    logic signed [31:0]         g_reg, g_next;
    logic signed [31:0]         basis_reg, basis_next;
    logic signed [65:0]         acc_reg [3];
    logic signed [65:0]         acc_next [3];
    logic                       ov_reg, ov_next;
    logic signed [31:0]         ox_reg, ox_next;
    logic signed [31:0]         oy_reg, oy_next;
    logic signed [31:0]         oz_reg, oz_next;
    logic [CNT_W-1:0]           ocnt_reg, ocnt_next;

    logic signed [32:0]         mul_a, mul_b;
    logic signed [65:0]         tsum, term;
    logic                       accept, out_free, cordic_start, cordic_done, rd_en;
    logic signed [31:0]         cos_v, sin_v;
    logic [31:0]                ph_sum;
    logic [XW-1:0]              idx_ext;
    logic                       idx_ok;
    fmfs_pkg::fmfs_wr_t         wr;
    logic [3*WAVE_BITS-1:0]     wr_k, rd_k;
    logic [95:0]                wr_v, rd_a, rd_b;
    logic [31:0]                rd_c;
    logic signed [31:0]         vin [3];
    logic [CNT_W-1:0]           mi_inc;

    assign vin[0]   = item.val_a;
    assign vin[1]   = item.val_b;
    assign vin[2]   = item.val_c;
    assign out_free = !ov_reg || result.ready;
    assign item.ready = (state_reg == S_IDLE) && out_free;
    assign accept   = item.valid && item.ready;
    assign idx_ext  = XW'(item.mode_index) + XW'(1);
    assign idx_ok   = idx_ext <= XW'(MAX_MODES);
    assign ph_sum   = ph_reg + prod_reg[31:0];
    assign mi_inc   = mi_reg + 1'b1;
    assign wr.en    = accept && !item.func[2] && idx_ok;
    assign wr.part  = item.func[1:0];
    assign wr_v     = {item.val_c, item.val_b, item.val_a};
    assign rd_en    = (state_reg == S_RD);
    assign cordic_start = (state_reg == S_PH3);

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (vin[j] > KMAX)
                wr_k[j*WAVE_BITS +: WAVE_BITS] = KMAX[WAVE_BITS-1:0];
            else if (vin[j] < KMIN)
                wr_k[j*WAVE_BITS +: WAVE_BITS] = KMIN[WAVE_BITS-1:0];
            else
                wr_k[j*WAVE_BITS +: WAVE_BITS] = vin[j][WAVE_BITS-1:0];
        end
    end

    fmfs_mode_table #(
        .MAX_MODES (MAX_MODES),
        .WAVE_BITS (WAVE_BITS),
        .IDX_W     (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr      (wr),
        .wr_addr (IDX_W'(item.mode_index)),
        .wr_k    (wr_k),
        .wr_v    (wr_v),
        .rd_en   (rd_en),
        .rd_addr (mi_reg[IDX_W-1:0]),
        .rd_k    (rd_k),
        .rd_a    (rd_a),
        .rd_b    (rd_b),
        .rd_c    (rd_c)
    );

    fmfs_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .phase   (ph_sum),
        .done    (cordic_done),
        .cos_out (cos_v),
        .sin_out (sin_v)
    );

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_FRAC0:
            begin
                mul_a = $signed({1'b0, d_reg[0]});
                mul_b = $signed({2'b00, inv_reg[0]});
            end
            S_FRAC1:
            begin
                mul_a = $signed({1'b0, d_reg[1]});
                mul_b = $signed({2'b00, inv_reg[1]});
            end
            S_FRAC2:
            begin
                mul_a = $signed({1'b0, d_reg[2]});
                mul_b = $signed({2'b00, inv_reg[2]});
            end
            S_PH0:
            begin
                mul_a = 33'($signed(rd_k[0 +: WAVE_BITS]));
                mul_b = $signed({1'b0, f_reg[0]});
            end
            S_PH1:
            begin
                mul_a = 33'($signed(rd_k[WAVE_BITS +: WAVE_BITS]));
                mul_b = $signed({1'b0, f_reg[1]});
            end
            S_PH2:
            begin
                mul_a = 33'($signed(rd_k[2*WAVE_BITS +: WAVE_BITS]));
                mul_b = $signed({1'b0, f_reg[2]});
            end
            S_G0:
            begin
                mul_a = 33'(gain_reg);
                mul_b = 33'($signed(rd_c));
            end
            S_A0:
            begin
                mul_a = 33'($signed(rd_a[ax_reg*32 +: 32]));
                mul_b = 33'(cos_v);
            end
            S_A1:
            begin
                mul_a = 33'($signed(rd_b[ax_reg*32 +: 32]));
                mul_b = 33'(sin_v);
            end
            S_A3:
            begin
                mul_a = 33'(g_reg);
                mul_b = 33'(basis_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign tsum = t_reg + prod_reg + (66'sd1 <<< 29);
    assign term = (prod_reg + 66'sd32768) >>> 16;

    always_comb
    begin
        state_next  = state_reg;
        enable_next = enable_reg;
        gain_next   = gain_reg;
        count_next  = count_reg;
        mi_next     = mi_reg;
        ax_next     = ax_reg;
        force_next  = force_reg;
        ph_next     = ph_reg;
        t_next      = t_reg;
        g_next      = g_reg;
        basis_next  = basis_reg;
        ov_next     = ov_reg && !result.ready;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        oz_next     = oz_reg;
        ocnt_next   = ocnt_reg;
        for (int j = 0; j < 3; j++)
        begin
            org_next[j] = org_reg[j];
            inv_next[j] = inv_reg[j];
            d_next[j]   = d_reg[j];
            f_next[j]   = f_reg[j];
            acc_next[j] = acc_reg[j];
        end

        if (cfg_write)
        begin
            unique case (cfg_index)
                fmfs_pkg::CFG_ENABLE:     enable_next = cfg_data[0];
                fmfs_pkg::CFG_ORIGIN_X:   org_next[0] = cfg_data;
                fmfs_pkg::CFG_ORIGIN_Y:   org_next[1] = cfg_data;
                fmfs_pkg::CFG_ORIGIN_Z:   org_next[2] = cfg_data;
                fmfs_pkg::CFG_INV_LEN_X:  inv_next[0] = cfg_data[30:0];
                fmfs_pkg::CFG_INV_LEN_Y:  inv_next[1] = cfg_data[30:0];
                fmfs_pkg::CFG_INV_LEN_Z:  inv_next[2] = cfg_data[30:0];
                default:                  gain_next   = cfg_data;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ox_next = '0;
                    oy_next = '0;
                    oz_next = '0;
                    if (!item.func[2])
                    begin
                        if (idx_ok && (XW'(count_reg) < idx_ext))
                            count_next = CNT_W'(idx_ext);
                        ocnt_next = (idx_ok && (XW'(count_reg) < idx_ext))
                                    ? CNT_W'(idx_ext) : count_reg;
                        ov_next   = 1'b1;
                    end
                    else if (item.func == fmfs_pkg::FUNC_CLEAR)
                    begin
                        count_next = '0;
                        ocnt_next  = '0;
                        ov_next    = 1'b1;
                    end
                    else if ((item.func == fmfs_pkg::FUNC_VELOCITY ||
                              item.func == fmfs_pkg::FUNC_FORCE) &&
                             enable_reg && (count_reg != '0))
                    begin
                        force_next = (item.func == fmfs_pkg::FUNC_FORCE);
                        for (int j = 0; j < 3; j++)
                        begin
                            d_next[j]   = vin[j] - org_reg[j];
                            acc_next[j] = '0;
                        end
                        mi_next    = '0;
                        ax_next    = '0;
                        state_next = S_FRAC0;
                    end
                    else
                    begin
                        ocnt_next = count_reg;
                        ov_next   = 1'b1;
                    end
                end
            end
            S_FRAC0: state_next = S_FRAC1;
            S_FRAC1:
            begin
                f_next[0]  = prod_reg[31:0];
                state_next = S_FRAC2;
            end
            S_FRAC2:
            begin
                f_next[1]  = prod_reg[31:0];
                state_next = S_FRAC3;
            end
            S_FRAC3:
            begin
                f_next[2]  = prod_reg[31:0];
                state_next = S_RD;
            end
            S_RD:  state_next = S_PH0;
            S_PH0: state_next = S_PH1;
            S_PH1:
            begin
                ph_next    = prod_reg[31:0];
                state_next = S_PH2;
            end
            S_PH2:
            begin
                ph_next    = ph_sum;
                state_next = S_PH3;
            end
            S_PH3: state_next = S_CW;
            S_CW:
            begin
                if (cordic_done)
                    state_next = force_reg ? S_G0 : S_A0;
            end
            S_G0: state_next = S_G1;
            S_G1:
            begin
                g_next     = fmfs_pkg::sat32(term);
                state_next = S_A0;
            end
            S_A0: state_next = S_A1;
            S_A1:
            begin
                t_next     = prod_reg;
                state_next = S_A2;
            end
            S_A2, S_A4:
            begin
                if (state_reg == S_A2)
                begin
                    basis_next = fmfs_pkg::sat32(tsum >>> 30);
                end
                if (state_reg == S_A2 && force_reg)
                begin
                    state_next = S_A3;
                end
                else
                begin
                    if (state_reg == S_A2)
                        acc_next[ax_reg] = acc_reg[ax_reg] + 66'(fmfs_pkg::sat32(tsum >>> 30));
                    else
                        acc_next[ax_reg] = acc_reg[ax_reg] + term;
                    if (ax_reg == 2'd2)
                    begin
                        ax_next = '0;
                        if (mi_inc == count_reg)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            mi_next    = mi_inc;
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        ax_next    = ax_reg + 1'b1;
                        state_next = S_A0;
                    end
                end
            end
            S_A3: state_next = S_A4;
            S_DONE:
            begin
                if (out_free)
                begin
                    ox_next    = fmfs_pkg::sat32(acc_reg[0]);
                    oy_next    = fmfs_pkg::sat32(acc_reg[1]);
                    oz_next    = fmfs_pkg::sat32(acc_reg[2]);
                    ocnt_next  = count_reg;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            enable_reg <= 1'b0;
            gain_reg   <= 32'sd65536;
            count_reg  <= '0;
            mi_reg     <= '0;
            ax_reg     <= '0;
            force_reg  <= 1'b0;
            ph_reg     <= '0;
            prod_reg   <= '0;
            t_reg      <= '0;
            g_reg      <= '0;
            basis_reg  <= '0;
            ov_reg     <= 1'b0;
            ox_reg     <= '0;
            oy_reg     <= '0;
            oz_reg     <= '0;
            ocnt_reg   <= '0;
            for (int j = 0; j < 3; j++)
            begin
                org_reg[j] <= '0;
                inv_reg[j] <= 31'd65536;
                d_reg[j]   <= '0;
                f_reg[j]   <= '0;
                acc_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            enable_reg <= enable_next;
            gain_reg   <= gain_next;
            count_reg  <= count_next;
            mi_reg     <= mi_next;
            ax_reg     <= ax_next;
            force_reg  <= force_next;
            ph_reg     <= ph_next;
            prod_reg   <= mul_a * mul_b;
            t_reg      <= t_next;
            g_reg      <= g_next;
            basis_reg  <= basis_next;
            ov_reg     <= ov_next;
            ox_reg     <= ox_next;
            oy_reg     <= oy_next;
            oz_reg     <= oz_next;
            ocnt_reg   <= ocnt_next;
            for (int j = 0; j < 3; j++)
            begin
                org_reg[j] <= org_next[j];
                inv_reg[j] <= inv_next[j];
                d_reg[j]   <= d_next[j];
                f_reg[j]   <= f_next[j];
                acc_reg[j] <= acc_next[j];
            end
        end
    end

    assign result.valid        = ov_reg;
    assign result.out_x        = ox_reg;
    assign result.out_y        = oy_reg;
    assign result.out_z        = oz_reg;
    assign result.modes_loaded = ocnt_reg;

endmodule
